@@ rtl/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and codes for the order book matcher
// Order kinds, status codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
package lobm_pkg;

  typedef enum logic [1:0] {
    OP_LIMIT  = 2'd0,
    OP_MARKET = 2'd1,
    OP_IOC    = 2'd2,
    OP_FOK    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RESTED   = 3'd0,
    ST_FILLED   = 3'd1,
    ST_CANCEL   = 3'd2,
    ST_KILLED   = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOK_SCAN,
    S_SCAN,
    S_FILL,
    S_SLOT_SCAN,
    S_CLOSE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;       // capture incoming order
    logic    scan_clr;   // reset scan pointer and best/free found flags
    logic    scan_step;  // examine one entry
    logic    fill;       // trade against chosen best entry, emit fill
    logic    rest;       // write remainder into free slot
    logic    close;      // emit closing record
    status_t status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;    // pointer examined last entry
    logic best_found;
    logic free_found;
    logic fok_short;    // eligible liquidity below quantity
    logic done_qty;     // filled == quantity
    logic op_limit;
    logic op_fok;
    logic out_busy;     // output register holds an untaken request
  } dp_sts_t;

endpackage

@@ rtl/lobm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lobm_ctrl: matcher sequencer
// Walks FOK liquidity check, best-entry scans, fills, slot search and close.
// ----------------------------------------------------------------------------
module lobm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lobm_pkg::dp_sts_t sts,
  output lobm_pkg::dp_cmd_t cmd
);
  import lobm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:
        if (in_valid) state_nxt = S_FOK_SCAN;
      S_FOK_SCAN:
        if (sts.scan_done) state_nxt = S_SCAN;
      S_SCAN:
        if (sts.op_fok && sts.fok_short) begin
          state_nxt = S_CLOSE;
        end else if (sts.scan_done) begin
          if (sts.done_qty)                  state_nxt = S_CLOSE;
          else if (sts.best_found)           state_nxt = S_FILL;
          else if (sts.op_limit)             state_nxt = S_SLOT_SCAN;
          else                               state_nxt = S_CLOSE;
        end
      S_FILL:
        if (!sts.out_busy) state_nxt = S_SCAN;
      S_SLOT_SCAN:
        if (sts.scan_done) state_nxt = S_CLOSE;
      S_CLOSE:
        if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load     = in_valid;
        cmd.scan_clr = in_valid;
      end
      S_FOK_SCAN: cmd.scan_step = 1'b1;
      S_SCAN: begin
        // FOK short: straight to close, which reports killed
        cmd.scan_step = !(sts.op_fok && sts.fok_short);
      end
      S_FILL: cmd.fill = !sts.out_busy;
      S_SLOT_SCAN: cmd.scan_step = 1'b1;
      S_CLOSE: begin
        cmd.close = !sts.out_busy;
        if (sts.op_fok && sts.fok_short)    cmd.status = ST_KILLED;
        else if (sts.done_qty)              cmd.status = ST_FILLED;
        else if (!sts.op_limit)             cmd.status = ST_CANCEL;
        else if (sts.free_found)            cmd.status = ST_RESTED;
        else                                cmd.status = ST_REJECTED;
        cmd.rest = !sts.out_busy && sts.op_limit && !sts.done_qty && sts.free_found;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> !cmd.close)
    else $error("fill and close together");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_FOK_SCAN)
    else $error("load did not start scan");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close |=> state_r == S_IDLE)
    else $error("close did not end order");
endmodule

@@ rtl/lobm_dp.sv @@
// ----------------------------------------------------------------------------
// lobm_dp: order table and matching datapath
// Resting table, serial scans, fill arithmetic and the output register.
// ----------------------------------------------------------------------------
module lobm_dp #(
  parameter int MAX_ORDERS = 32,
  parameter int PRICE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_opcode,
  input  logic              in_order_side,
  input  logic              in_has_limit,
  input  logic [31:0]       in_limit_price,
  input  logic [31:0]       in_quantity,
  input  logic [31:0]       in_taker_id,
  input  lobm_pkg::dp_cmd_t cmd,
  output lobm_pkg::dp_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [31:0]       out_order_ref,
  output logic [31:0]       out_maker_id,
  output logic [31:0]       out_fill_qty,
  output logic [31:0]       out_fill_price,
  output logic [31:0]       out_filled_total,
  output logic [2:0]        out_status,
  output logic              out_last
);
  import lobm_pkg::*;

  localparam int IW = $clog2(MAX_ORDERS);
  localparam int PW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
  localparam int AW = 33 + IW;

  // table: valid bits in flops, payload in registers indexed by scan pointer, best or free slot
  logic [MAX_ORDERS-1:0] vld_r;
  logic                  e_side_r  [MAX_ORDERS];
  logic [PW-1:0]         e_price_r [MAX_ORDERS];
  logic [31:0]           e_qty_r   [MAX_ORDERS];
  logic [31:0]           e_id_r    [MAX_ORDERS];
  logic [31:0]           e_seq_r   [MAX_ORDERS];
  logic [31:0]           arr_r;

  op_t          op_r;
  logic         side_r, bnd_r;
  logic [PW-1:0] lim_r;
  logic [31:0]  qty_r, tid_r, filled_r;
  logic [IW-1:0] ptr_r;
  logic         best_ok_r;
  logic [IW-1:0] best_r;
  logic [PW-1:0] best_price_r;
  logic [31:0]  best_age_r;
  logic [AW-1:0] avail_r;
  logic         free_ok_r;
  logic [IW-1:0] free_r;
  logic         fok_flag_r;
  logic         fok_done_r;

  logic [IW-1:0] idx;
  logic          elig, better, last_step;
  logic          cur_best_ok, cur_free_ok;
  logic [PW-1:0] pi;
  logic [31:0]   age, rem, amt;
  logic [AW-1:0] avail_sum;
  logic          out_busy;

  assign idx       = ptr_r;
  assign last_step = (ptr_r == IW'(MAX_ORDERS-1));
  // first step of a scan starts fresh
  assign cur_best_ok = best_ok_r && (ptr_r != '0);
  assign cur_free_ok = free_ok_r && (ptr_r != '0);
  assign pi        = e_price_r[idx];
  assign age       = arr_r - e_seq_r[idx];
  assign elig      = vld_r[idx] && (e_side_r[idx] != side_r) &&
                     (!bnd_r || (side_r ? (pi >= lim_r) : (pi <= lim_r)));
  assign better    = !cur_best_ok ||
                     (side_r ? (pi > best_price_r) : (pi < best_price_r)) ||
                     (pi == best_price_r && age > best_age_r);
  assign rem       = qty_r - filled_r;
  assign amt       = (e_qty_r[best_r] < rem) ? e_qty_r[best_r] : rem;
  assign avail_sum = avail_r + (elig ? {{(AW-32){1'b0}}, e_qty_r[idx]} : '0);

  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      arr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.fill) begin
        out_valid <= 1'b1;
        if (e_qty_r[best_r] == amt) vld_r[best_r] <= 1'b0;
      end
      if (cmd.close) out_valid <= 1'b1;
      if (cmd.rest) begin
        vld_r[free_r] <= 1'b1;
        arr_r         <= arr_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_opcode);
      side_r   <= in_order_side;
      bnd_r    <= (in_opcode == OP_LIMIT) ? 1'b1 :
                  (in_opcode == OP_MARKET) ? 1'b0 : in_has_limit;
      lim_r    <= in_limit_price[PW-1:0];
      qty_r    <= in_quantity;
      tid_r    <= in_taker_id;
      filled_r <= '0;
      avail_r  <= '0;
    end
    if (cmd.scan_clr) begin
      ptr_r     <= '0;
      best_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.scan_step) begin
      ptr_r     <= last_step ? '0 : ptr_r + 1'b1;
      avail_r   <= avail_sum;
      best_ok_r <= cur_best_ok || elig;
      free_ok_r <= cur_free_ok || !vld_r[idx];
      if (elig && better) begin
        best_r       <= idx;
        best_price_r <= pi;
        best_age_r   <= age;
      end
      if (!vld_r[idx] && !cur_free_ok) free_r <= idx;
    end
    if (cmd.fill) begin
      filled_r        <= filled_r + amt;
      e_qty_r[best_r] <= e_qty_r[best_r] - amt;
    end
    if (cmd.rest) begin
      e_side_r[free_r]  <= side_r;
      e_price_r[free_r] <= lim_r;
      e_qty_r[free_r]   <= rem;
      e_id_r[free_r]    <= tid_r;
      e_seq_r[free_r]   <= arr_r;
    end
    if (cmd.fill) begin
      out_kind         <= 1'b0;
      out_order_ref    <= tid_r;
      out_maker_id     <= e_id_r[best_r];
      out_fill_qty     <= amt;
      out_fill_price   <= 32'(best_price_r);
      out_filled_total <= filled_r + amt;
      out_status       <= ST_RESTED;
      out_last         <= 1'b0;
    end
    if (cmd.close) begin
      out_kind         <= 1'b1;
      out_order_ref    <= tid_r;
      out_maker_id     <= '0;
      out_fill_qty     <= '0;
      out_fill_price   <= '0;
      out_filled_total <= (cmd.status == ST_KILLED) ? 32'd0 : filled_r;
      out_status       <= cmd.status;
      out_last         <= 1'b1;
    end
  end

  // FOK check: liquidity sum complete at the last step of the first scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fok_flag_r <= 1'b0;
      fok_done_r <= 1'b0;
    end else if (cmd.scan_step && last_step && !fok_done_r) begin
      fok_done_r <= 1'b1;
      fok_flag_r <= (op_r == OP_FOK) && (avail_sum < {{(AW-32){1'b0}}, qty_r});
    end
  end

  assign sts.scan_done  = cmd.scan_step && last_step;
  assign sts.best_found = cur_best_ok || (elig && cmd.scan_step);
  assign sts.free_found = free_ok_r;
  assign sts.fok_short  = fok_flag_r;
  assign sts.done_qty   = (filled_r == qty_r);
  assign sts.op_limit   = (op_r == OP_LIMIT);
  assign sts.op_fok     = (op_r == OP_FOK);
  assign sts.out_busy   = out_busy;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> vld_r[best_r])
    else $error("fill on invalid entry");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rest |-> !vld_r[free_r])
    else $error("rest into occupied slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> amt != '0)
    else $error("zero fill");
endmodule

@@ rtl/limit_order_book_matcher_top.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top: price-time priority order matcher
// Channel  | ports          | direction
// in       | in_valid/stall | order request in
// out      | out_valid/stall| fill and close requests out
// One order at a time: accept, a liquidity scan over all MAX_ORDERS entries,
// then per fill a best-entry scan plus the fill, a final best-entry scan, a
// free-slot search scan for an unfilled limit, then the close.
// A killed FOK goes from S_SCAN straight to close without scanning; in_stall is high
// after the accept until the close request is issued.
// Reset is synchronous and clears the valid bits and arrival counter.
// Out stall holds fill and close while the output register is still full.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top #(
  parameter int MAX_ORDERS = 32,
  parameter int PRICE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic        in_order_side,
  input  logic        in_has_limit,
  input  logic [31:0] in_limit_price,
  input  logic [31:0] in_quantity,
  input  logic [31:0] in_taker_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_order_ref,
  output logic [31:0] out_maker_id,
  output logic [31:0] out_fill_qty,
  output logic [31:0] out_fill_price,
  output logic [31:0] out_filled_total,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import lobm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  lobm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  lobm_dp #(.MAX_ORDERS(MAX_ORDERS), .PRICE_BITS(PRICE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_opcode(in_opcode), .in_order_side(in_order_side),
    .in_has_limit(in_has_limit), .in_limit_price(in_limit_price),
    .in_quantity(in_quantity), .in_taker_id(in_taker_id),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_order_ref(out_order_ref), .out_maker_id(out_maker_id),
    .out_fill_qty(out_fill_qty), .out_fill_price(out_fill_price),
    .out_filled_total(out_filled_total), .out_status(out_status),
    .out_last(out_last)
  );
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for limit_order_book_matcher_top
// Drives orders through the request channel and predicts each fill and closing
// record from a local copy of the order book. Records are checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import lobm_pkg::*;

  localparam int BOOK_DEPTH  = 32;
  localparam int IDLE_LIMIT  = 40000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    bit        kind;
    bit [31:0] order_ref;
    bit [31:0] maker;
    bit [31:0] qty;
    bit [31:0] price;
    bit [31:0] total;
    bit [2:0]  status;
    bit        last;
  } book_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic        in_order_side;
  logic        in_has_limit;
  logic [31:0] in_limit_price;
  logic [31:0] in_quantity;
  logic [31:0] in_taker_id;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [31:0] out_order_ref;
  logic [31:0] out_maker_id;
  logic [31:0] out_fill_qty;
  logic [31:0] out_fill_price;
  logic [31:0] out_filled_total;
  logic [2:0]  out_status;
  logic        out_last;

  // local book
  bit        bk_valid [BOOK_DEPTH];
  bit        bk_side  [BOOK_DEPTH];
  bit [31:0] bk_price [BOOK_DEPTH];
  bit [31:0] bk_qty   [BOOK_DEPTH];
  bit [31:0] bk_id    [BOOK_DEPTH];
  bit [31:0] bk_seq   [BOOK_DEPTH];
  bit [31:0] arrivals;

  book_rec_t trade_q[$];
  int        errors = 0;
  int        idle_pct;
  int        stall_pct;
  int        hold_tag = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  limit_order_book_matcher_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit price_fits(bit side, bit bounded, bit [31:0] lim, bit [31:0] p);
    if (!bounded) return 1'b1;
    return side ? (p >= lim) : (p <= lim);
  endfunction

  function automatic int best_entry(bit side, bit bounded, bit [31:0] lim);
    int        best;
    bit        better;
    bit [31:0] age_i;
    bit [31:0] age_b;
    best = -1;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (!bk_valid[i] || bk_side[i] == side) continue;
      if (!price_fits(side, bounded, lim, bk_price[i])) continue;
      if (best < 0) begin
        best = i;
      end else begin
        better = side ? (bk_price[i] > bk_price[best]) : (bk_price[i] < bk_price[best]);
        if (!better && bk_price[i] == bk_price[best]) begin
          age_i = arrivals - bk_seq[i];
          age_b = arrivals - bk_seq[best];
          better = age_i > age_b;
        end
        if (better) best = i;
      end
    end
    return best;
  endfunction

  function automatic book_rec_t close_rec(bit [31:0] id, bit [31:0] total, status_t st);
    book_rec_t r;
    r = '{1'b1, id, 32'd0, 32'd0, 32'd0, total, st, 1'b1};
    return r;
  endfunction

  task automatic queue_rec(book_rec_t r);
    trade_q.insert(trade_q.size(), r);
  endtask

  // match one order against the local book and queue the expected records
  task automatic match_order(op_t op, bit side, bit hl, bit [31:0] lim, bit [31:0] q,
                             bit [31:0] id);
    bit        bounded;
    bit [31:0] filled;
    bit [31:0] amt;
    longint    avail;
    int        b;
    int        slot;
    status_t   st;
    book_rec_t r;
    bounded = (op == OP_LIMIT) ? 1'b1 : (op == OP_MARKET ? 1'b0 : hl);
    filled = 0;
    if (op == OP_FOK) begin
      avail = 0;
      for (int i = 0; i < BOOK_DEPTH; i++)
        if (bk_valid[i] && bk_side[i] != side && price_fits(side, bounded, lim, bk_price[i]))
          avail += bk_qty[i];
      if (avail < longint'(q)) begin
        queue_rec(close_rec(id, 32'd0, ST_KILLED));
        return;
      end
    end
    while (filled < q) begin
      b = best_entry(side, bounded, lim);
      if (b < 0) break;
      amt = (bk_qty[b] < q - filled) ? bk_qty[b] : q - filled;
      filled += amt;
      bk_qty[b] -= amt;
      r = '{1'b0, id, bk_id[b], amt, bk_price[b], filled, 3'd0, 1'b0};
      queue_rec(r);
      if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
    end
    if (filled >= q) begin
      st = ST_FILLED;
    end else if (op != OP_LIMIT) begin
      st = ST_CANCEL;
    end else begin
      slot = -1;
      for (int i = 0; i < BOOK_DEPTH; i++)
        if (!bk_valid[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        st = ST_REJECTED;
      end else begin
        bk_valid[slot] = 1'b1;
        bk_side[slot]  = side;
        bk_price[slot] = lim;
        bk_qty[slot]   = q - filled;
        bk_id[slot]    = id;
        bk_seq[slot]   = arrivals;
        arrivals++;
        st = ST_RESTED;
      end
    end
    queue_rec(close_rec(id, filled, st));
  endtask

  task automatic send_order(op_t op, bit side, bit hl, bit [31:0] lim, bit [31:0] q,
                            bit [31:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_order_side  = side;
    in_has_limit   = hl;
    in_limit_price = lim;
    in_quantity    = q;
    in_taker_id    = id;
    do @(posedge clk); while (in_stall);
    match_order(op, side, hl, lim, q, id);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (trade_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report(string what, bit [31:0] got, bit [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    book_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (trade_q.size() == 0) begin
        report("unexpected record ref", out_order_ref, 32'd0);
      end else begin
        e = trade_q.pop_front();
        if (out_kind != e.kind) report("kind", 32'(out_kind), 32'(e.kind));
        if (out_order_ref != e.order_ref) report("order_ref", out_order_ref, e.order_ref);
        if (out_maker_id != e.maker) report("maker_id", out_maker_id, e.maker);
        if (out_fill_qty != e.qty) report("fill_qty", out_fill_qty, e.qty);
        if (out_fill_price != e.price) report("fill_price", out_fill_price, e.price);
        if (out_filled_total != e.total) report("filled_total", out_filled_total, e.total);
        if (out_status != e.status) report("status", 32'(out_status), 32'(e.status));
        if (out_last != e.last) report("last", 32'(out_last), 32'(e.last));
      end
    end
  end

  // receiver stall, with a long hold when requested
  always @(negedge clk) begin
    if (hold_seen != hold_tag) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic random_order();
    op_t       op;
    bit [31:0] p;
    bit [31:0] q;
    int        pick;
    op = op_t'($urandom_range(3));
    pick = $urandom_range(99);
    p = (pick < 88) ? 32'd1000 + $urandom_range(15) : $urandom;
    pick = $urandom_range(99);
    if (pick < 82) q = $urandom_range(1, 30);
    else if (pick < 90) q = $urandom;
    else if (pick < 95) q = 32'd0;
    else q = 32'hFFFF_FFFF;
    // markets stay small most of the time so the book keeps some depth
    if (op == OP_MARKET && pick < 95 && $urandom_range(3) != 0) q = $urandom_range(1, 40);
    send_order(op, 1'($urandom_range(1)), 1'($urandom_range(1)), p, q, $urandom);
  endtask

  task automatic test_directed();
    send_order(OP_LIMIT, 1'b0, 1'b0, 32'd100, 32'd10, 32'd1);
    send_order(OP_LIMIT, 1'b0, 1'b1, 32'd100, 32'd5, 32'd2);
    send_order(OP_LIMIT, 1'b0, 1'b1, 32'd101, 32'd7, 32'd3);
    send_order(OP_LIMIT, 1'b1, 1'b1, 32'd100, 32'd12, 32'hFFFF_FFFF);
    send_order(OP_MARKET, 1'b1, 1'b1, 32'd500, 32'd3, 32'd5);
    send_order(OP_IOC, 1'b1, 1'b1, 32'd101, 32'd50, 32'd6);
    send_order(OP_IOC, 1'b1, 1'b0, 32'd0, 32'd4, 32'd7);
    send_order(OP_FOK, 1'b1, 1'b1, 32'd0, 32'd1000, 32'd8);
    send_order(OP_FOK, 1'b1, 1'b0, 32'd0, 32'd2, 32'd9);
    send_order(OP_LIMIT, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd10);
    send_order(OP_LIMIT, 1'b1, 1'b0, 32'd0, 32'd0, 32'd11);
    send_order(OP_LIMIT, 1'b1, 1'b0, 32'd200, 32'd9, 32'd12);
    send_order(OP_FOK, 1'b0, 1'b1, 32'd300, 32'd9, 32'd13);
    send_order(OP_MARKET, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd14);
    send_order(OP_MARKET, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd15);
    wait_drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < BOOK_DEPTH; i++)
      send_order(OP_LIMIT, 1'b0, 1'b1, 32'd50 + (i % 3), 32'd2, 32'd100 + i);
    send_order(OP_LIMIT, 1'b0, 1'b1, 32'd40, 32'd2, 32'd200);
    send_order(OP_LIMIT, 1'b1, 1'b1, 32'd52, 32'd5, 32'd201);
    send_order(OP_MARKET, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd202);
    wait_drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) random_order();
    wait_drain();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_tag++;
    for (int i = 0; i < 12; i++) random_order();
    wait_drain();
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    arrivals = 0;
    for (int i = 0; i < BOOK_DEPTH; i++) bk_valid[i] = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_LIMIT;
    in_order_side = 1'b0;
    in_has_limit = 1'b0;
    in_limit_price = '0;
    in_quantity = '0;
    in_taker_id = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_table_full();
    test_random(110, 0, 0);
    test_random(100, 82, 0);
    test_random(100, 0, 82);
    test_random(110, 31, 31);
    test_backpressure();
    test_random(10, 0, 0);
    if (errors == 0 && trade_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ limit_order_book_matcher_top.f @@
rtl/lobm_pkg.sv
rtl/lobm_ctrl.sv
rtl/lobm_dp.sv
rtl/limit_order_book_matcher_top.sv
tb/tb.sv
